[rtl/core/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int PAYLOAD_WIDTH  = 32;
    localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                       operation;
        logic [PRIORITY_WIDTH-1:0] priority_req;
        logic [PAYLOAD_WIDTH-1:0]  payload;
    } t_in;

    typedef struct packed {
        t_status                   status;
        logic [PAYLOAD_WIDTH-1:0]  removed_payload;
        logic [PRIORITY_WIDTH-1:0] removed_priority;
        logic [PAYLOAD_WIDTH-1:0]  head_payload;
        logic [PRIORITY_WIDTH-1:0] head_priority;
        logic [CNT_W-1:0]          occupancy;
    } t_out;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] pri;
        logic [PAYLOAD_WIDTH-1:0]  pay;
    } t_entry;

    // Per-beat control broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

[rtl/core/spq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module spq_cell (
    input  logic                          i_clk,
    input  spq_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_valid,
    input  spq_pkg::t_entry               i_new,
    input  spq_pkg::t_entry               i_left,
    input  logic                          i_left_goes,
    input  spq_pkg::t_entry               i_right,
    output spq_pkg::t_entry               o_entry,
    output logic                          o_goes
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Move aside when empty or holding a strictly larger priority
    assign o_goes = !i_valid || (r_entry.pri > i_new.pri);

    // Pick next content: keep, take left neighbor, take new entry, or take right
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_goes) begin
            n_entry = i_left_goes ? i_left : i_new;
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: cell chain, count and result register.
//
// Bounded priority queue of spq_pkg::QUEUE_DEPTH entries kept in ascending
// priority order in a chain of cells; equal priorities leave in arrival order.
// Each input beat (insert or remove) is done as one chain update: every cell
// compares its priority with the new one in parallel and the whole chain shifts
// at once; a beat goes in each cycle o_in_ready is high, its result lands on
// the output register on the next cycle. The output register is one deep; input
// is taken whenever that register is empty or is being drained in the same cycle.
// Every result carries status, the removed entry, the head after the beat and
// the occupancy. Stored slots at or above the occupancy hold no meaning.
module sorted_priority_queue_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  spq_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output spq_pkg::t_out  o_out
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
    localparam int CW    = spq_pkg::CNT_W;

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    spq_pkg::t_out      r_out;
    spq_pkg::t_out      n_out;

    spq_pkg::t_entry    cell_q    [DEPTH];
    logic               cell_goes [DEPTH];
    spq_pkg::t_entry    new_entry;
    spq_pkg::t_cell_ctl ctl;

    logic accept;
    logic is_full;
    logic is_empty;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    assign new_entry.pri = i_in.priority_req;
    assign new_entry.pay = i_in.payload;

    // Drive chain shifts only for beats that change the queue
    assign ctl.ins = accept && (i_in.operation == spq_pkg::OP_INSERT) && !is_full;
    assign ctl.rem = accept && (i_in.operation == spq_pkg::OP_REMOVE) && !is_empty;

    // Build the chain
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        spq_pkg::t_entry left_e;
        spq_pkg::t_entry right_e;
        logic            left_g;

        if (k == 0) begin : g_first
            assign left_e = '0;
            assign left_g = 1'b0;
        end else begin : g_mid
            assign left_e = cell_q[k-1];
            assign left_g = cell_goes[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cell_q[k+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_valid     (CW'(k) < r_count),
            .i_new       (new_entry),
            .i_left      (left_e),
            .i_left_goes (left_g),
            .i_right     (right_e),
            .o_entry     (cell_q[k]),
            .o_goes      (cell_goes[k])
        );
    end

    // Form the result and the next count
    always_comb begin
        n_count                = r_count;
        n_out                  = '0;
        n_out.status           = spq_pkg::ST_OK;
        if (i_in.operation == spq_pkg::OP_INSERT) begin
            if (is_full) begin
                n_out.status = spq_pkg::ST_FULL;
                n_out.head_payload  = cell_q[0].pay;
                n_out.head_priority = cell_q[0].pri;
            end else begin
                n_count = r_count + 1'b1;
                if (cell_goes[0]) begin
                    n_out.head_payload  = new_entry.pay;
                    n_out.head_priority = new_entry.pri;
                end else begin
                    n_out.head_payload  = cell_q[0].pay;
                    n_out.head_priority = cell_q[0].pri;
                end
            end
        end else begin
            if (is_empty) begin
                n_out.status = spq_pkg::ST_EMPTY;
            end else begin
                n_count                = r_count - 1'b1;
                n_out.removed_payload  = cell_q[0].pay;
                n_out.removed_priority = cell_q[0].pri;
                if (r_count > CW'(1)) begin
                    n_out.head_payload  = cell_q[1].pay;
                    n_out.head_priority = cell_q[1].pri;
                end
            end
        end
        n_out.occupancy = n_count;
    end

    // Hold count and output handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load result payload on each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Occupancy never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    // Full status only with a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == spq_pkg::ST_FULL) |->
        (o_out.occupancy == CW'(DEPTH)))
        else $error("full status with room left");

    // Empty status only with an empty queue
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == spq_pkg::ST_EMPTY) |->
        (o_out.occupancy == '0))
        else $error("empty status with entries stored");

    // Front two cells stay in order
    a_sorted_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > CW'(1)) |-> (cell_q[0].pri <= cell_q[1].pri))
        else $error("chain head out of order");

endmodule

[test/tb_sorted_priority_queue_core.sv]
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int  RUN_LIMIT_NS   = 2_000_000;
    localparam int  RESET_CYCLES   = 11;
    localparam int  SETTLE_CYCLES  = 8;
    localparam int  RANDOM_ITEMS   = 720;
    localparam int  REPORT_LIMIT   = 10;

    logic i_clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_beat;
    logic out_valid;
    logic out_ready;
    t_out out_beat;

    // Software copy of the sorted queue
    t_entry queue_entries [QUEUE_DEPTH];
    int     queue_count;

    t_out   pending_results [$];
    t_out   oldest_result;

    int  mismatch_count    = 0;
    int  results_checked   = 0;
    int  accepted_inserts  = 0;
    int  accepted_removes  = 0;
    int  refused_full      = 0;
    int  refused_empty     = 0;
    int  peak_occupancy    = 0;
    int  sink_hold_cycles  = 0;
    bit  src_steady        = 1'b0;
    bit  sink_steady       = 1'b0;

    sorted_priority_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    always #2 i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in make_beat(t_op op, logic [PRIORITY_WIDTH-1:0] pri,
                                      logic [PAYLOAD_WIDTH-1:0] pay);
        t_in beat;
        beat.operation    = op;
        beat.priority_req = pri;
        beat.payload      = pay;
        return beat;
    endfunction

    // Apply one beat to the queue copy and return the result it must produce
    function automatic t_out predict_queue_step(t_in beat);
        t_out res;
        int   slot;
        res        = '0;
        res.status = ST_OK;
        if (beat.operation == OP_INSERT) begin
            if (queue_count >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
                refused_full++;
            end else begin
                // Place before the first strictly greater priority
                slot = queue_count;
                for (int k = queue_count - 1; k >= 0; k--) begin
                    if (queue_entries[k].pri > beat.priority_req) slot = k;
                end
                for (int k = queue_count; k > slot; k--) begin
                    queue_entries[k] = queue_entries[k-1];
                end
                queue_entries[slot].pri = beat.priority_req;
                queue_entries[slot].pay = beat.payload;
                queue_count++;
                accepted_inserts++;
            end
        end else begin
            if (queue_count == 0) begin
                res.status = ST_EMPTY;
                refused_empty++;
            end else begin
                res.removed_payload  = queue_entries[0].pay;
                res.removed_priority = queue_entries[0].pri;
                for (int k = 1; k < queue_count; k++) begin
                    queue_entries[k-1] = queue_entries[k];
                end
                queue_count--;
                accepted_removes++;
            end
        end
        if (queue_count > 0) begin
            res.head_payload  = queue_entries[0].pay;
            res.head_priority = queue_entries[0].pri;
        end
        res.occupancy = CNT_W'(queue_count);
        if (queue_count > peak_occupancy) peak_occupancy = queue_count;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("Mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
                         field, results_checked, want, got);
            end
        end
    endtask

    // Offer one beat after an optional gap and hold it until accepted
    task automatic send_beat(input t_in beat);
        int gap;
        gap = src_steady ? 0 : random_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (!in_ready);
        pending_results.push_back(predict_queue_step(beat));
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Extremes of both fields, ties in arrival order, both refusals on empty
    task automatic test_directed_edges();
        send_beat(make_beat(OP_REMOVE, 8'd0, 32'h0));
        send_beat(make_beat(OP_INSERT, 8'd200, 32'h0000_0001));
        send_beat(make_beat(OP_INSERT, 8'd0, 32'h0000_0000));
        send_beat(make_beat(OP_INSERT, 8'd255, 32'hFFFF_FFFF));
        send_beat(make_beat(OP_INSERT, 8'd128, 32'hA5A5_A5A5));
        send_beat(make_beat(OP_INSERT, 8'd128, 32'h5A5A_5A5A));
        send_beat(make_beat(OP_INSERT, 8'd0, 32'h8000_0000));
        send_beat(make_beat(OP_INSERT, 8'd255, 32'h7FFF_FFFE));
        repeat (7) send_beat(make_beat(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF));
        send_beat(make_beat(OP_REMOVE, 8'd77, 32'h1234_5678));
        wait_drained();
    endtask

    // Hold off the sink so the core stalls, fill past full, then empty it out
    task automatic test_backpressure_fill();
        sink_hold_cycles = 80;
        while (sink_hold_cycles != 0) @(posedge i_clk);
        src_steady = 1'b1;
        repeat (QUEUE_DEPTH + 2) begin
            send_beat(make_beat(OP_INSERT, 8'($urandom_range(0, 15)), $urandom()));
        end
        src_steady = 1'b0;
        wait_drained();
        repeat (QUEUE_DEPTH + 1) begin
            send_beat(make_beat(OP_REMOVE, 8'($urandom_range(0, 255)), $urandom()));
        end
        wait_drained();
    endtask

    // Bursts with a biased insert mix so occupancy swings between empty and full
    task automatic test_random_traffic(input int n_items);
        int  sent;
        int  burst;
        int  insert_pct;
        int  pri_mode;
        t_in beat;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(15, 60);
            case ($urandom_range(0, 3))
                0: insert_pct = 25;
                1: insert_pct = 50;
                2: insert_pct = 75;
                default: insert_pct = 90;
            endcase
            pri_mode    = $urandom_range(0, 2);
            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            repeat (burst) begin
                beat.operation = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                case (pri_mode)
                    0: beat.priority_req = 8'($urandom_range(0, 255));
                    1: beat.priority_req = 8'($urandom_range(0, 3));
                    default: begin
                        case ($urandom_range(0, 3))
                            0: beat.priority_req = 8'd0;
                            1: beat.priority_req = 8'd1;
                            2: beat.priority_req = 8'd254;
                            default: beat.priority_req = 8'd255;
                        endcase
                    end
                endcase
                beat.payload = $urandom();
                send_beat(beat);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result beat: 0x%0h", out_beat);
                end
            end else begin
                oldest_result = pending_results.pop_front();
                compare_field("status", oldest_result.status, out_beat.status);
                compare_field("removed_payload", oldest_result.removed_payload,
                              out_beat.removed_payload);
                compare_field("removed_priority", oldest_result.removed_priority,
                              out_beat.removed_priority);
                compare_field("head_payload", oldest_result.head_payload,
                              out_beat.head_payload);
                compare_field("head_priority", oldest_result.head_priority,
                              out_beat.head_priority);
                compare_field("occupancy", oldest_result.occupancy, out_beat.occupancy);
                results_checked++;
            end
        end
    end

    // Pace the sink: random stalls, steady stretches, and requested hold-offs
    initial begin : sink_pacing
        int held;
        int stall;
        out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                held = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ready <= 1'b0;
                repeat (held) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            repeat (sink_steady ? 1 : $urandom_range(1, 12)) @(posedge i_clk);
            if (!sink_steady) begin
                stall = random_gap();
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Bound the run in case the core hangs
    initial begin
        #RUN_LIMIT_NS;
        $display("Verification failed");
        $finish;
    end

    initial begin
        queue_count = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_beat  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_backpressure_fill();
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts, %0d removes, %0d full refusals, %0d empty refusals",
                 results_checked, accepted_inserts, accepted_removes, refused_full,
                 refused_empty);
        $display("Peak occupancy %0d of %0d, mismatches %0d", peak_occupancy, QUEUE_DEPTH,
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
test/tb_sorted_priority_queue_core.sv
